[sv/m3i_pkg.sv]
`timescale 1ns / 1ps
// Package for the 3x3 matrix inverse core: widths, payload types and the cofactor table.
// Used by every module of the block; depends on nothing else.
package m3i_pkg;
	localparam int DW    = 32;
	localparam int FB    = 16;
	localparam int N_EL  = 9;
	localparam int PW    = 2 * DW;
	localparam int CW    = 2 * DW + 1;
	localparam int DETW  = 3 * DW + 1;
	localparam int CMAGW = 2 * DW;
	localparam int DMAGW = 3 * DW;
	localparam int DNW   = DMAGW + 1;
	localparam int NSH   = 2 * FB + 1;
	localparam int NW    = ((CMAGW + NSH > DMAGW) ? CMAGW + NSH : DMAGW) + 1;
	localparam int CMPW  = (NW > DNW + DW) ? NW : DNW + DW;

	typedef logic [3:0] el_idx_t;
	typedef logic signed [DW-1:0] elem_t;
	typedef logic signed [CW-1:0] cof_t;

	// Cofactor i = a[PA]*a[PB] - a[MA]*a[MB], elements numbered row * 3 + column.
	localparam el_idx_t COF_PA [N_EL] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
	localparam el_idx_t COF_PB [N_EL] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
	localparam el_idx_t COF_MA [N_EL] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
	localparam el_idx_t COF_MB [N_EL] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

	typedef struct packed {
		logic signed [DW-1:0] elem_r0c0;
		logic signed [DW-1:0] elem_r0c1;
		logic signed [DW-1:0] elem_r0c2;
		logic signed [DW-1:0] elem_r1c0;
		logic signed [DW-1:0] elem_r1c1;
		logic signed [DW-1:0] elem_r1c2;
		logic signed [DW-1:0] elem_r2c0;
		logic signed [DW-1:0] elem_r2c1;
		logic signed [DW-1:0] elem_r2c2;
	} mat_t;

	typedef struct packed {
		logic signed [DW-1:0] inv_r0c0;
		logic signed [DW-1:0] inv_r0c1;
		logic signed [DW-1:0] inv_r0c2;
		logic signed [DW-1:0] inv_r1c0;
		logic signed [DW-1:0] inv_r1c1;
		logic signed [DW-1:0] inv_r1c2;
		logic signed [DW-1:0] inv_r2c0;
		logic signed [DW-1:0] inv_r2c1;
		logic signed [DW-1:0] inv_r2c2;
		logic                 singular;
		logic                 saturated;
	} inv_t;

	typedef struct packed {
		logic [NW-1:0] num;
		logic          neg;
	} lane_op_t;

	typedef struct packed {
		logic [DW-1:0] quo;
		logic          ovf;
		logic          neg;
	} lane_res_t;
endpackage

[sv/m3i_cofactor.sv]
`timescale 1ns / 1ps
// Cofactor front end: two-term products of the elements, then the nine adjugate cofactors.
// Depends on m3i_pkg.
module m3i_cofactor import m3i_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  mat_t  mat,
	output cof_t  cof [N_EL],
	output elem_t row0 [3]
);
	elem_t a [N_EL];
	logic signed [PW-1:0] pp_s1 [N_EL];
	logic signed [PW-1:0] pm_s1 [N_EL];
	elem_t row0_s1 [3];
	cof_t  cof_s2 [N_EL];
	elem_t row0_s2 [3];

	assign a[0] = mat.elem_r0c0;
	assign a[1] = mat.elem_r0c1;
	assign a[2] = mat.elem_r0c2;
	assign a[3] = mat.elem_r1c0;
	assign a[4] = mat.elem_r1c1;
	assign a[5] = mat.elem_r1c2;
	assign a[6] = mat.elem_r2c0;
	assign a[7] = mat.elem_r2c1;
	assign a[8] = mat.elem_r2c2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_EL; i++) begin
				pp_s1[i] <= a[COF_PA[i]] * a[COF_PB[i]];
				pm_s1[i] <= a[COF_MA[i]] * a[COF_MB[i]];
				cof_s2[i] <= {pp_s1[i][PW-1], pp_s1[i]} - {pm_s1[i][PW-1], pm_s1[i]};
			end
			for (int j = 0; j < 3; j++) begin
				row0_s1[j] <= a[j];
				row0_s2[j] <= row0_s1[j];
			end
		end
	end

	assign cof  = cof_s2;
	assign row0 = row0_s2;
endmodule

[sv/m3i_det.sv]
`timescale 1ns / 1ps
// Determinant by expansion along row 0 with split multiplies, then divider operands per lane.
// Depends on m3i_pkg.
module m3i_det import m3i_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  cof_t           cof [N_EL],
	input  elem_t          row0 [3],
	output lane_op_t       op [N_EL],
	output logic [DNW-1:0] den,
	output logic           zero
);
	logic signed [2*DW:0]   lo_s3 [3];
	logic signed [2*DW:0]   hi_s3 [3];
	logic signed [DETW-1:0] term_s4 [3];
	logic signed [DETW-1:0] det_s5;
	cof_t cof_s3 [N_EL];
	cof_t cof_s4 [N_EL];
	cof_t cof_s5 [N_EL];
	logic [DMAGW-1:0] dmag_s6;
	logic             dneg_s6;
	logic             zero_s6;
	logic [CMAGW-1:0] cmag_s6 [N_EL];
	logic             cneg_s6 [N_EL];
	lane_op_t         op_s7 [N_EL];
	logic [DNW-1:0]   den_s7;
	logic             zero_s7;
	logic [DETW-1:0]  det_abs;
	logic [CW-1:0]    cof_abs [N_EL];

	always_comb begin
		det_abs = det_s5[DETW-1] ? -det_s5 : det_s5;
		for (int i = 0; i < N_EL; i++) begin
			cof_abs[i] = cof_s5[i][CW-1] ? -cof_s5[i] : cof_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				lo_s3[j] <= row0[j] * $signed({1'b0, cof[3*j][DW-1:0]});
				hi_s3[j] <= row0[j] * $signed(cof[3*j][CW-1:DW]);
				term_s4[j] <= (DETW'(hi_s3[j]) <<< DW) + DETW'(lo_s3[j]);
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			dneg_s6 <= det_s5[DETW-1];
			zero_s6 <= (det_s5 == '0);
			dmag_s6 <= det_abs[DMAGW-1:0];
			for (int i = 0; i < N_EL; i++) begin
				cof_s3[i]  <= cof[i];
				cof_s4[i]  <= cof_s3[i];
				cof_s5[i]  <= cof_s4[i];
				cmag_s6[i] <= cof_abs[i][CMAGW-1:0];
				cneg_s6[i] <= cof_s5[i][CW-1];
				op_s7[i].num <= (NW'(cmag_s6[i]) << NSH) + NW'(dmag_s6);
				op_s7[i].neg <= cneg_s6[i] ^ dneg_s6;
			end
			den_s7  <= {dmag_s6, 1'b0};
			zero_s7 <= zero_s6;
		end
	end

	assign op   = op_s7;
	assign den  = den_s7;
	assign zero = zero_s7;
endmodule

[sv/m3i_div_lane.sv]
`timescale 1ns / 1ps
// One divider lane: overflow check, then a restoring quotient pipeline, one bit per stage.
// Depends on m3i_pkg; the divisor pipeline is shared by all lanes and held in the top level.
module m3i_div_lane import m3i_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  lane_op_t       op,
	input  logic [DNW-1:0] den,
	input  logic [DNW-1:0] den_stg [DW],
	output lane_res_t      res
);
	logic [NW-1:0] rem_s [DW+1];
	logic [DW-1:0] quo_s [DW+1];
	logic          ovf_s [DW+1];
	logic          neg_s [DW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= op.num;
			quo_s[0] <= '0;
			ovf_s[0] <= CMPW'(op.num) >= (CMPW'(den) << DW);
			neg_s[0] <= op.neg;
		end
	end

	for (genvar j = 0; j < DW; j++) begin : g_stage
		logic [CMPW-1:0] cmp_den;
		logic [CMPW-1:0] diff;
		logic            ge;

		assign cmp_den = CMPW'(den_stg[j]) << (DW - 1 - j);
		assign ge      = CMPW'(rem_s[j]) >= cmp_den;
		assign diff    = CMPW'(rem_s[j]) - cmp_den;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? diff[NW-1:0] : rem_s[j];
				quo_s[j+1] <= quo_s[j] | (DW'(ge) << (DW - 1 - j));
				ovf_s[j+1] <= ovf_s[j];
				neg_s[j+1] <= neg_s[j];
			end
		end
	end

	assign res.quo = quo_s[DW];
	assign res.ovf = ovf_s[DW];
	assign res.neg = neg_s[DW];
endmodule

[sv/m3i_merge.sv]
`timescale 1ns / 1ps
// Merging stage: signs, saturation and the singular case applied to all nine lanes.
// Depends on m3i_pkg.
module m3i_merge import m3i_pkg::*; (
	input  lane_res_t lres [N_EL],
	input  logic      zero,
	output inv_t      res
);
	logic [DW-1:0]   lim [N_EL];
	logic [DW-1:0]   mag [N_EL];
	logic [DW-1:0]   val [N_EL];
	logic [N_EL-1:0] sat;

	always_comb begin
		for (int i = 0; i < N_EL; i++) begin
			lim[i] = {lres[i].neg, {(DW-1){~lres[i].neg}}};
			sat[i] = lres[i].ovf || (lres[i].quo > lim[i]);
			mag[i] = sat[i] ? lim[i] : lres[i].quo;
			val[i] = lres[i].neg ? -mag[i] : mag[i];
			if (zero) begin
				val[i] = '0;
			end
		end
	end

	assign res.inv_r0c0  = val[0];
	assign res.inv_r0c1  = val[1];
	assign res.inv_r0c2  = val[2];
	assign res.inv_r1c0  = val[3];
	assign res.inv_r1c1  = val[4];
	assign res.inv_r1c2  = val[5];
	assign res.inv_r2c0  = val[6];
	assign res.inv_r2c1  = val[7];
	assign res.inv_r2c2  = val[8];
	assign res.singular  = zero;
	assign res.saturated = !zero && (|sat);
endmodule

[sv/matrix_3x3_inverse_core.sv]
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, nine signed Q16.16 elements in, nine out.
// Depends on m3i_pkg, m3i_cofactor, m3i_det, m3i_div_lane and m3i_merge.
//
// The matrix channel (mat_valid, mat_stall, mat) takes one matrix per transfer and the
// result channel (inv_valid, inv_stall, inv) returns one inverse per transfer, in order.
// A result passes through the element products and cofactors, then determinant and operand
// preparation, then 33 stages of the nine parallel divider lanes (an overflow check, then
// one quotient bit per stage), with the output register last.
// With inv_stall low the block takes a matrix every cycle.
// When the receiver stalls, the pipeline keeps running into one spare result register;
// once that register holds a result, mat_stall rises and the whole pipeline holds until
// the receiver takes the waiting result. mat_stall is a register output.
// A zero determinant gives all-zero elements with singular set; saturated reports any
// element clipped to the signed 32-bit range.
// Reset clears all valid flags; the block takes a matrix in the first cycle after reset.
module matrix_3x3_inverse_core import m3i_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic mat_valid,
	output logic mat_stall,
	input  mat_t mat,
	output logic inv_valid,
	input  logic inv_stall,
	output inv_t inv
);
	localparam int NST = 7 + DW + 1;

	logic [NST-1:0] v_q;
	logic           en;
	logic           take;
	cof_t           cof [N_EL];
	elem_t          row0 [3];
	lane_op_t       op [N_EL];
	logic [DNW-1:0] den_s7;
	logic           zero_s7;
	logic [DNW-1:0] den_s [DW];
	logic           zero_s [DW+1];
	lane_res_t      lres [N_EL];
	inv_t           merged;
	inv_t           out_q;
	logic           out_v_q;
	inv_t           skid_q;
	logic           skid_v_q;

	assign en        = !skid_v_q;
	assign take      = en && v_q[NST-1];
	assign mat_stall = skid_v_q;
	assign inv_valid = out_v_q;
	assign inv       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-2:0], mat_valid};
		end
	end

	m3i_cofactor u_cof (
		.clk  (clk),
		.en   (en),
		.mat  (mat),
		.cof  (cof),
		.row0 (row0)
	);

	m3i_det u_det (
		.clk  (clk),
		.en   (en),
		.cof  (cof),
		.row0 (row0),
		.op   (op),
		.den  (den_s7),
		.zero (zero_s7)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= den_s7;
			zero_s[0] <= zero_s7;
			for (int j = 1; j < DW; j++) begin
				den_s[j] <= den_s[j-1];
			end
			for (int j = 1; j <= DW; j++) begin
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	for (genvar i = 0; i < N_EL; i++) begin : g_lane
		m3i_div_lane u_lane (
			.clk     (clk),
			.en      (en),
			.op      (op[i]),
			.den     (den_s7),
			.den_stg (den_s),
			.res     (lres[i])
		);
	end

	m3i_merge u_merge (
		.lres (lres),
		.zero (zero_s[DW]),
		.res  (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !inv_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !inv_stall) begin
			out_q <= skid_v_q ? skid_q : merged;
		end else if (take) begin
			skid_q <= merged;
		end
	end
endmodule

[sv/m3i_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the matrix inverse core, attached to the top level by bind.
// Depends on m3i_pkg and matrix_3x3_inverse_core.
module m3i_checker import m3i_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic mat_valid,
	input logic mat_stall,
	input mat_t mat,
	input logic inv_valid,
	input logic inv_stall,
	input inv_t inv
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_stall |=> inv_valid && $stable(inv))
		else $error("result changed while stalled");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.singular |-> inv.inv_r0c0 == '0 && inv.inv_r0c1 == '0 &&
		inv.inv_r0c2 == '0 && inv.inv_r1c0 == '0 && inv.inv_r1c1 == '0 &&
		inv.inv_r1c2 == '0 && inv.inv_r2c0 == '0 && inv.inv_r2c1 == '0 &&
		inv.inv_r2c2 == '0 && !inv.saturated)
		else $error("singular result is not all zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mat_stall) |-> $past(inv_valid && inv_stall))
		else $error("input stalled without a stalled result");

	a_stall_waits: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall |-> inv_valid)
		else $error("input stalled with no result waiting");
endmodule

bind matrix_3x3_inverse_core m3i_checker u_m3i_checker (.*);
